// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the nearest point search RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define NVE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define NVE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/nve_pkg.sv
// Package of the nearest vertex and edge point search: beat types, codes,
// controller states, datapath operations and status. No dependencies.
package nve_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VERTICES_IN_USE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGES_IN_USE    = 4'd1;

  // Command codes.
  localparam logic [1:0] CMD_LOAD_VTX  = 2'd0;
  localparam logic [1:0] CMD_LOAD_EDGE = 2'd1;
  localparam logic [1:0] CMD_NEAR_VTX  = 2'd2;
  localparam logic [1:0] CMD_NEAR_EDGE = 2'd3;

  localparam logic [16:0] LAMBDA_ONE = 17'd65536;

  typedef struct packed {
    logic [1:0]         command;
    logic [10:0]        entry_index;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
    logic signed [23:0] coord_z;
    logic               vertex_enabled;
    logic [9:0]         end_a;
    logic [9:0]         end_b;
    logic [22:0]        radius;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [10:0]        hit_index;
    logic signed [23:0] near_x;
    logic signed [23:0] near_y;
    logic signed [23:0] near_z;
    logic [24:0]        distance;
    logic [49:0]        distance_squared;
    logic [16:0]        lambda;
  } out_item_t;

  typedef struct packed {
    logic               on;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } vtx_word_t;

  typedef struct packed {
    logic       valid;
    logic [9:0] a;
    logic [9:0] b;
  } edge_word_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    ST_V_RD, ST_V_DIF, ST_V_SQ, ST_V_CMP,
    ST_E_RD, ST_E_VRD, ST_E_DIF, ST_E_DOT, ST_E_LEN, ST_E_CLAMP, ST_E_DIV,
    ST_E_PNT, ST_E_CPT, ST_E_CD, ST_E_CSQ, ST_E_CMP,
    ST_SQ_INIT, ST_SQ_STEP, ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_ACCEPT,
    OP_V_RD, OP_V_DIF, OP_V_SQ, OP_V_CMP,
    OP_E_RD, OP_E_VRD, OP_E_DIF, OP_E_DOT, OP_E_LEN, OP_E_CLAMP, OP_E_DIV,
    OP_E_PNT, OP_E_CPT, OP_E_CD, OP_E_CSQ, OP_E_CMP,
    OP_SQ_INIT, OP_SQ_STEP, OP_OUT
  } op_t;

  typedef struct packed {
    logic scan_end;
    logic usable;
    logic need_div;
    logic div_last;
    logic sqrt_last;
    logic clr_last;
  } dp_stat_t;

endpackage

// File: hw/rtl/nve_datapath.sv
// Datapath of the nearest point search: tables, configuration registers,
// three multiplier lanes, divider, square root and result register.
// Depends on nve_pkg.
module nve_datapath #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 2048
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  nve_pkg::op_t                   op,
  input  nve_pkg::in_item_t              in_item,
  input  logic                           cfg_valid,
  input  logic [nve_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nve_pkg::CFG_DATA_W-1:0] cfg_data,
  output nve_pkg::dp_stat_t              stat,
  output logic                           out_valid,
  output nve_pkg::out_item_t             out_result
);

  localparam int VAW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int EAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CLR_N = (MAX_VERTICES > MAX_EDGES) ? MAX_VERTICES : MAX_EDGES;
  localparam int CLW   = $clog2(CLR_N);

  // Configuration registers, saturated at the table depths.
  logic [10:0] viu_r;
  logic [11:0] eiu_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      viu_r <= '0;
      eiu_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == nve_pkg::CFG_VERTICES_IN_USE) begin
        viu_r <= (int'(cfg_data[10:0]) > MAX_VERTICES) ? 11'(MAX_VERTICES) : cfg_data[10:0];
      end else if (cfg_index == nve_pkg::CFG_EDGES_IN_USE) begin
        eiu_r <= (int'(cfg_data) > MAX_EDGES) ? 12'(MAX_EDGES) : cfg_data;
      end
    end
  end

  // Clearing pass counter after reset.
  logic [CLW-1:0] clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (op == nve_pkg::OP_CLEAR) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // Query registers.
  logic signed [23:0] p_r [3];
  logic               qv_r;
  logic [11:0]        scan_r;
  logic               found_r;
  logic [10:0]        hit_r;
  logic [49:0]        best_r;
  logic [16:0]        lam_out_r;
  logic signed [23:0] near_r [3];
  logic signed [23:0] vpos_r [3];
  logic               von_r;

  // Table memories and their ports.
  nve_pkg::vtx_word_t  vmem [MAX_VERTICES];
  nve_pkg::edge_word_t emem [MAX_EDGES];
  nve_pkg::vtx_word_t  vqa, vqb, v_wd;
  nve_pkg::edge_word_t eq, e_wd;
  logic                v_we, e_we, v_rea, v_reb, e_re;
  logic [VAW-1:0]      v_wa, v_ra, v_rb;
  logic [EAW-1:0]      e_wa, e_ra;

  // Write and read port selection.
  always_comb begin
    v_we = 1'b0;
    e_we = 1'b0;
    v_wa = VAW'(clr_r);
    e_wa = EAW'(clr_r);
    v_wd = '0;
    e_wd = '0;
    if (op == nve_pkg::OP_CLEAR) begin
      v_we = int'(clr_r) < MAX_VERTICES;
      e_we = int'(clr_r) < MAX_EDGES;
    end else if (op == nve_pkg::OP_ACCEPT) begin
      v_wa = VAW'(in_item.entry_index);
      e_wa = EAW'(in_item.entry_index);
      v_wd = '{on: in_item.vertex_enabled, x: in_item.coord_x, y: in_item.coord_y,
               z: in_item.coord_z};
      e_wd = '{valid: (in_item.end_a != in_item.end_b), a: in_item.end_a, b: in_item.end_b};
      v_we = (in_item.command == nve_pkg::CMD_LOAD_VTX) &&
             (int'(in_item.entry_index) < MAX_VERTICES);
      e_we = (in_item.command == nve_pkg::CMD_LOAD_EDGE) &&
             (int'(in_item.entry_index) < MAX_EDGES);
    end
    v_rea = (op == nve_pkg::OP_V_RD) || (op == nve_pkg::OP_E_VRD);
    v_reb = (op == nve_pkg::OP_E_VRD);
    e_re  = (op == nve_pkg::OP_E_RD);
    v_ra  = (op == nve_pkg::OP_E_VRD) ? VAW'(eq.a) : VAW'(scan_r);
    v_rb  = VAW'(eq.b);
    e_ra  = EAW'(scan_r);
  end

  always_ff @(posedge clk) begin
    if (v_we) vmem[v_wa] <= v_wd;
    if (v_rea) vqa <= vmem[v_ra];
    if (v_reb) vqb <= vmem[v_rb];
  end

  always_ff @(posedge clk) begin
    if (e_we) emem[e_wa] <= e_wd;
    if (e_re) eq <= emem[e_ra];
  end

  // Lane views of the memory read data.
  logic signed [23:0] va_c [3];
  logic signed [23:0] vb_c [3];

  always_comb begin
    va_c[0] = vqa.x; va_c[1] = vqa.y; va_c[2] = vqa.z;
    vb_c[0] = vqb.x; vb_c[1] = vqb.y; vb_c[2] = vqb.z;
  end

  // Lane registers and one multiplier per lane.
  logic signed [24:0] diff_r [3];
  logic signed [24:0] dir_r  [3];
  logic signed [24:0] q_r    [3];
  logic signed [23:0] a_r    [3];
  logic signed [23:0] c_r    [3];
  logic signed [49:0] prod_r [3];
  logic signed [24:0] ma     [3];
  logic signed [24:0] mb     [3];
  logic signed [49:0] mul_p  [3];
  logic signed [49:0] rnd    [3];
  logic signed [33:0] shr    [3];
  logic [16:0]        lam_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unique case (op)
        nve_pkg::OP_E_DOT: begin ma[k] = dir_r[k]; mb[k] = q_r[k]; end
        nve_pkg::OP_E_LEN: begin ma[k] = dir_r[k]; mb[k] = dir_r[k]; end
        nve_pkg::OP_E_PNT: begin ma[k] = dir_r[k]; mb[k] = signed'({8'b0, lam_r}); end
        default:           begin ma[k] = diff_r[k]; mb[k] = diff_r[k]; end
      endcase
      mul_p[k] = ma[k] * mb[k];
      rnd[k]   = prod_r[k] + 50'sd32768;
      shr[k]   = 34'(rnd[k] >>> 16);
    end
  end

  // Sum of the three lane products.
  logic signed [51:0] sum_s;
  logic [49:0]        dist_c;

  assign sum_s  = 52'(prod_r[0]) + 52'(prod_r[1]) + 52'(prod_r[2]);
  assign dist_c = sum_s[49:0];

  // Projection clamp decision and divider step.
  logic signed [51:0] dot_r;
  logic [49:0]        len_r;
  logic [49:0]        rem_r;
  logic [3:0]         div_cnt_r;
  logic               dot_pos, dot_ge, rem_ge;
  logic [50:0]        rem_sh;

  assign dot_pos = !dot_r[51] && (dot_r != '0);
  assign dot_ge  = dot_r >= $signed({2'b00, dist_c});
  assign rem_sh  = {rem_r, 1'b0};
  assign rem_ge  = rem_sh >= {1'b0, len_r};

  // Square root step.
  logic [49:0] sv_r;
  logic [26:0] srem_r;
  logic [24:0] root_r;
  logic [4:0]  sq_cnt_r;
  logic [28:0] srem_t, strial;
  logic        s_ge;

  assign srem_t = {srem_r, sv_r[49:48]};
  assign strial = {2'b00, root_r, 2'b01};
  assign s_ge   = srem_t >= strial;

  // Edge usability for the entry just read.
  logic usable_c;

  assign usable_c = eq.valid && ({1'b0, eq.a} < viu_r) && ({1'b0, eq.b} < viu_r) &&
                    vqa.on && vqb.on;

  // Status back to the controller.
  always_comb begin
    stat.scan_end  = qv_r ? ({1'b0, viu_r} <= scan_r) : (eiu_r <= scan_r);
    stat.usable    = usable_c;
    stat.need_div  = (dist_c != '0) && dot_pos && !dot_ge;
    stat.div_last  = (div_cnt_r == 4'd15);
    stat.sqrt_last = (sq_cnt_r == 5'd24);
    stat.clr_last  = (clr_r == CLW'(CLR_N - 1));
  end

  // Radius squared for the starting best of an edge query.
  logic [45:0] rsq;

  assign rsq = in_item.radius * in_item.radius;

  // Operation sequencing of the datapath registers.
  always_ff @(posedge clk) begin
    unique case (op)
      nve_pkg::OP_ACCEPT: begin
        p_r[0]    <= in_item.coord_x;
        p_r[1]    <= in_item.coord_y;
        p_r[2]    <= in_item.coord_z;
        qv_r      <= (in_item.command == nve_pkg::CMD_NEAR_VTX);
        scan_r    <= '0;
        found_r   <= 1'b0;
        best_r    <= 50'(rsq);
        lam_out_r <= '0;
      end
      nve_pkg::OP_V_DIF: begin
        for (int k = 0; k < 3; k++) begin
          diff_r[k] <= 25'(va_c[k]) - 25'(p_r[k]);
          vpos_r[k] <= va_c[k];
        end
        von_r <= vqa.on;
      end
      nve_pkg::OP_V_SQ, nve_pkg::OP_E_DOT, nve_pkg::OP_E_PNT, nve_pkg::OP_E_CSQ: begin
        for (int k = 0; k < 3; k++) prod_r[k] <= mul_p[k];
      end
      nve_pkg::OP_V_CMP: begin
        if (von_r && (!found_r || dist_c < best_r)) begin
          found_r <= 1'b1;
          hit_r   <= scan_r[10:0];
          best_r  <= dist_c;
          for (int k = 0; k < 3; k++) near_r[k] <= vpos_r[k];
        end
        scan_r <= scan_r + 1'b1;
      end
      nve_pkg::OP_E_DIF: begin
        for (int k = 0; k < 3; k++) begin
          dir_r[k] <= 25'(vb_c[k]) - 25'(va_c[k]);
          q_r[k]   <= 25'(p_r[k]) - 25'(va_c[k]);
          a_r[k]   <= va_c[k];
        end
        if (!usable_c) scan_r <= scan_r + 1'b1;
      end
      nve_pkg::OP_E_LEN: begin
        dot_r <= sum_s;
        for (int k = 0; k < 3; k++) prod_r[k] <= mul_p[k];
      end
      nve_pkg::OP_E_CLAMP: begin
        len_r     <= dist_c;
        rem_r     <= dot_r[49:0];
        div_cnt_r <= '0;
        if ((dist_c == '0) || !dot_pos) begin
          lam_r <= '0;
        end else if (dot_ge) begin
          lam_r <= nve_pkg::LAMBDA_ONE;
        end else begin
          lam_r <= '0;
        end
      end
      nve_pkg::OP_E_DIV: begin
        rem_r     <= rem_ge ? 50'(rem_sh - {1'b0, len_r}) : rem_sh[49:0];
        lam_r     <= {lam_r[15:0], rem_ge};
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      nve_pkg::OP_E_CPT: begin
        for (int k = 0; k < 3; k++) c_r[k] <= 24'(26'(a_r[k]) + shr[k][25:0]);
      end
      nve_pkg::OP_E_CD: begin
        for (int k = 0; k < 3; k++) diff_r[k] <= 25'(c_r[k]) - 25'(p_r[k]);
      end
      nve_pkg::OP_E_CMP: begin
        if (dist_c <= best_r) begin
          found_r   <= 1'b1;
          hit_r     <= scan_r[10:0];
          best_r    <= dist_c;
          lam_out_r <= lam_r;
          for (int k = 0; k < 3; k++) near_r[k] <= c_r[k];
        end
        scan_r <= scan_r + 1'b1;
      end
      nve_pkg::OP_SQ_INIT: begin
        sv_r     <= found_r ? best_r : '0;
        srem_r   <= '0;
        root_r   <= '0;
        sq_cnt_r <= '0;
      end
      nve_pkg::OP_SQ_STEP: begin
        srem_r   <= s_ge ? 27'(srem_t - strial) : srem_t[26:0];
        root_r   <= {root_r[23:0], s_ge};
        sv_r     <= {sv_r[47:0], 2'b00};
        sq_cnt_r <= sq_cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Result register: one beat per query, zero fields when nothing was found.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (op == nve_pkg::OP_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (op == nve_pkg::OP_OUT) begin
      out_result.found            <= found_r;
      out_result.hit_index        <= found_r ? hit_r : '0;
      out_result.near_x           <= found_r ? near_r[0] : '0;
      out_result.near_y           <= found_r ? near_r[1] : '0;
      out_result.near_z           <= found_r ? near_r[2] : '0;
      out_result.distance         <= root_r;
      out_result.distance_squared <= found_r ? best_r : '0;
      out_result.lambda           <= found_r ? lam_out_r : '0;
    end
  end

endmodule

// File: hw/rtl/nve_ctrl.sv
// Controller state machine of the nearest point search: sequences the
// datapath operations per table entry. Depends on nve_pkg, assert_macros.svh.
`include "assert_macros.svh"

module nve_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        command,
  input  nve_pkg::dp_stat_t stat,
  output logic              busy,
  output nve_pkg::op_t      op
);

  nve_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nve_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != nve_pkg::ST_IDLE);

  // Next state and datapath operation.
  always_comb begin
    state_nxt = state_r;
    op        = nve_pkg::OP_NONE;
    unique case (state_r)
      nve_pkg::ST_CLEAR: begin
        op = nve_pkg::OP_CLEAR;
        if (stat.clr_last) state_nxt = nve_pkg::ST_IDLE;
      end
      nve_pkg::ST_IDLE: begin
        if (start) begin
          op = nve_pkg::OP_ACCEPT;
          if (command == nve_pkg::CMD_NEAR_VTX) state_nxt = nve_pkg::ST_V_RD;
          else if (command == nve_pkg::CMD_NEAR_EDGE) state_nxt = nve_pkg::ST_E_RD;
        end
      end
      nve_pkg::ST_V_RD: begin
        op        = nve_pkg::OP_V_RD;
        state_nxt = stat.scan_end ? nve_pkg::ST_SQ_INIT : nve_pkg::ST_V_DIF;
      end
      nve_pkg::ST_V_DIF: begin
        op = nve_pkg::OP_V_DIF; state_nxt = nve_pkg::ST_V_SQ;
      end
      nve_pkg::ST_V_SQ: begin
        op = nve_pkg::OP_V_SQ; state_nxt = nve_pkg::ST_V_CMP;
      end
      nve_pkg::ST_V_CMP: begin
        op = nve_pkg::OP_V_CMP; state_nxt = nve_pkg::ST_V_RD;
      end
      nve_pkg::ST_E_RD: begin
        op        = nve_pkg::OP_E_RD;
        state_nxt = stat.scan_end ? nve_pkg::ST_SQ_INIT : nve_pkg::ST_E_VRD;
      end
      nve_pkg::ST_E_VRD: begin
        op = nve_pkg::OP_E_VRD; state_nxt = nve_pkg::ST_E_DIF;
      end
      nve_pkg::ST_E_DIF: begin
        op        = nve_pkg::OP_E_DIF;
        state_nxt = stat.usable ? nve_pkg::ST_E_DOT : nve_pkg::ST_E_RD;
      end
      nve_pkg::ST_E_DOT: begin
        op = nve_pkg::OP_E_DOT; state_nxt = nve_pkg::ST_E_LEN;
      end
      nve_pkg::ST_E_LEN: begin
        op = nve_pkg::OP_E_LEN; state_nxt = nve_pkg::ST_E_CLAMP;
      end
      nve_pkg::ST_E_CLAMP: begin
        op        = nve_pkg::OP_E_CLAMP;
        state_nxt = stat.need_div ? nve_pkg::ST_E_DIV : nve_pkg::ST_E_PNT;
      end
      nve_pkg::ST_E_DIV: begin
        op = nve_pkg::OP_E_DIV;
        if (stat.div_last) state_nxt = nve_pkg::ST_E_PNT;
      end
      nve_pkg::ST_E_PNT: begin
        op = nve_pkg::OP_E_PNT; state_nxt = nve_pkg::ST_E_CPT;
      end
      nve_pkg::ST_E_CPT: begin
        op = nve_pkg::OP_E_CPT; state_nxt = nve_pkg::ST_E_CD;
      end
      nve_pkg::ST_E_CD: begin
        op = nve_pkg::OP_E_CD; state_nxt = nve_pkg::ST_E_CSQ;
      end
      nve_pkg::ST_E_CSQ: begin
        op = nve_pkg::OP_E_CSQ; state_nxt = nve_pkg::ST_E_CMP;
      end
      nve_pkg::ST_E_CMP: begin
        op = nve_pkg::OP_E_CMP; state_nxt = nve_pkg::ST_E_RD;
      end
      nve_pkg::ST_SQ_INIT: begin
        op = nve_pkg::OP_SQ_INIT; state_nxt = nve_pkg::ST_SQ_STEP;
      end
      nve_pkg::ST_SQ_STEP: begin
        op = nve_pkg::OP_SQ_STEP;
        if (stat.sqrt_last) state_nxt = nve_pkg::ST_OUT;
      end
      nve_pkg::ST_OUT: begin
        op = nve_pkg::OP_OUT; state_nxt = nve_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = nve_pkg::ST_IDLE;
      end
    endcase
  end

  // A load beat finishes in the cycle it is taken.
  `NVE_ASSERT(a_load_no_busy, clk, rst_n, (!busy && start && (command == nve_pkg::CMD_LOAD_VTX || command == nve_pkg::CMD_LOAD_EDGE)) |=> !busy, "load left the block busy")
  // The result beat is followed by idle.
  `NVE_ASSERT(a_out_then_idle, clk, rst_n, (state_r == nve_pkg::ST_OUT) |=> !busy, "no idle after result")
  // The divider leaves after its last quotient bit.
  `NVE_ASSERT(a_div_exit, clk, rst_n, (state_r == nve_pkg::ST_E_DIV && stat.div_last) |=> (state_r == nve_pkg::ST_E_PNT), "divider overran")
  // Reset always starts the clearing pass.
  `NVE_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> (state_r == nve_pkg::ST_CLEAR), "reset did not start clearing")

endmodule

// File: hw/rtl/nearest_vertex_and_edge_point_search.sv
// Top level of the nearest vertex and edge point search.
// Joins nve_ctrl and nve_datapath; depends on nve_pkg.
//
// After reset the block clears the enable and valid flags of every table
// entry, one entry a cycle, with busy high. A load command completes in the
// cycle in which it is taken. A query is accepted, then per vertex reads,
// subtracts, squares and compares; per edge it reads the edge and its two
// vertices, skips an unusable edge, else forms dot product and length, clamps,
// divides bit-serially when the factor lies strictly inside the edge, forms the
// point, squares its distance and compares. Both end with a read that finds the
// table end, a bit-serial square root (a set-up step and 25 bit-pair steps) and
// a step that loads the result register. The result is marked by out_valid
// for exactly one cycle and cannot be held off.
module nearest_vertex_and_edge_point_search #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 2048
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  nve_pkg::in_item_t              in_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nve_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nve_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  output nve_pkg::out_item_t             out_result
);

  nve_pkg::op_t      op;
  nve_pkg::dp_stat_t stat;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  nve_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .command (in_item.command),
    .stat    (stat),
    .busy    (busy),
    .op      (op)
  );

  nve_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .in_item    (in_item),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

// File: dv/testbench.sv
// Self-checking testbench of the nearest vertex and edge point search.
// Depends on nve_pkg and the top level nearest_vertex_and_edge_point_search;
// its own table model predicts every query result.
module testbench;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  nve_pkg::in_item_t   in_item;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [nve_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [nve_pkg::CFG_DATA_W-1:0] cfg_data;
  logic       out_valid;
  nve_pkg::out_item_t  out_result;

  nearest_vertex_and_edge_point_search uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_result(out_result)
  );

  localparam int NV = 1024;
  localparam int NE = 2048;
  localparam int WATCHDOG_LIMIT = 300000;

  // Shadow copy of the vertex and edge tables and the two registers.
  logic signed [23:0] vtx_x [NV];
  logic signed [23:0] vtx_y [NV];
  logic signed [23:0] vtx_z [NV];
  bit                 vtx_on [NV];
  logic [9:0]         edge_a [NE];
  logic [9:0]         edge_b [NE];
  bit                 edge_ok [NE];
  int unsigned        vtx_count;
  int unsigned        edge_count;

  nve_pkg::in_item_t  pending_cmds [$];
  nve_pkg::out_item_t awaited_hits [$];
  int        idle_pct;
  int        errors;
  int        queries_seen;
  int        quiet_cycles;
  logic      took;

  // Clock; the single reset at the start of the run is driven by the stimulus sequence.
  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic bit vtx_usable(int unsigned i);
    return i < vtx_count && vtx_on[i];
  endfunction

  // Apply one command to the table copy; returns 1 when a result is due.
  function automatic bit search_predict(nve_pkg::in_item_t c, output nve_pkg::out_item_t r);
    longint px, py, pz, ax, ay, az, dx, dy, dz, dot, cx, cy, cz;
    longint unsigned best, d, len2, lam, lam_best;
    logic [81:0] quot;
    bit hit_any;
    int unsigned hit;
    px = c.coord_x; py = c.coord_y; pz = c.coord_z;
    r = '0;
    hit_any = 0; hit = 0; best = 0; lam_best = 0;
    cx = 0; cy = 0; cz = 0;
    case (c.command)
      nve_pkg::CMD_LOAD_VTX: begin
        if (c.entry_index < NV) begin
          vtx_x[c.entry_index] = c.coord_x;
          vtx_y[c.entry_index] = c.coord_y;
          vtx_z[c.entry_index] = c.coord_z;
          vtx_on[c.entry_index] = c.vertex_enabled;
        end
        return 0;
      end
      nve_pkg::CMD_LOAD_EDGE: begin
        edge_a[c.entry_index] = c.end_a;
        edge_b[c.entry_index] = c.end_b;
        edge_ok[c.entry_index] = c.end_a != c.end_b;
        return 0;
      end
      nve_pkg::CMD_NEAR_VTX: begin
        // First strictly smaller squared distance wins.
        for (int i = 0; i < vtx_count; i++) begin
          if (!vtx_on[i]) continue;
          dx = longint'(vtx_x[i]) - px;
          dy = longint'(vtx_y[i]) - py;
          dz = longint'(vtx_z[i]) - pz;
          d = dx * dx + dy * dy + dz * dz;
          if (!hit_any || d < best) begin
            hit_any = 1; hit = i; best = d;
            r.near_x = vtx_x[i]; r.near_y = vtx_y[i]; r.near_z = vtx_z[i];
          end
        end
      end
      default: begin
        // Edge search: later ties win, start from radius squared.
        best = longint'(c.radius) * longint'(c.radius);
        for (int i = 0; i < edge_count; i++) begin
          if (!edge_ok[i] || !vtx_usable(edge_a[i]) || !vtx_usable(edge_b[i])) continue;
          ax = vtx_x[edge_a[i]]; ay = vtx_y[edge_a[i]]; az = vtx_z[edge_a[i]];
          dx = longint'(vtx_x[edge_b[i]]) - ax;
          dy = longint'(vtx_y[edge_b[i]]) - ay;
          dz = longint'(vtx_z[edge_b[i]]) - az;
          dot = dx * (px - ax) + dy * (py - ay) + dz * (pz - az);
          len2 = dx * dx + dy * dy + dz * dz;
          if (len2 == 0 || dot <= 0) begin
            lam = 0;
          end else if (unsigned'(dot) >= len2) begin
            lam = 65536;
          end else begin
            quot = {18'd0, dot[63:0]} << 16;
            quot = quot / {18'd0, len2};
            lam = quot[63:0];
          end
          cx = ax + ((dx * longint'(lam) + 32768) >>> 16);
          cy = ay + ((dy * longint'(lam) + 32768) >>> 16);
          cz = az + ((dz * longint'(lam) + 32768) >>> 16);
          d = (cx - px) * (cx - px) + (cy - py) * (cy - py) + (cz - pz) * (cz - pz);
          if (d > best) continue;
          hit_any = 1; hit = i; best = d; lam_best = lam;
          r.near_x = cx[23:0]; r.near_y = cy[23:0]; r.near_z = cz[23:0];
        end
      end
    endcase
    if (!hit_any) begin
      r = '0;
    end else begin
      r.found = 1'b1;
      r.hit_index = hit[10:0];
      r.distance = 25'(int_sqrt(best));
      r.distance_squared = best[49:0];
      r.lambda = lam_best[16:0];
    end
    return 1;
  endfunction

  task automatic field_check(string name, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
      errors++;
    end
  endtask

  // Monitor: predict on every accepted beat, check every result beat.
  always @(posedge clk) begin
    nve_pkg::out_item_t want;
    if (!rst_n) begin
      took <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      took <= start && !busy;
      if (out_valid) begin
        if (awaited_hits.size() == 0) begin
          $display("%0t: unexpected result %0h", $time, out_result);
          errors++;
        end else begin
          want = awaited_hits.pop_front();
          queries_seen++;
          field_check("found", want.found, out_result.found);
          field_check("hit_index", want.hit_index, out_result.hit_index);
          field_check("near_x", want.near_x, out_result.near_x);
          field_check("near_y", want.near_y, out_result.near_y);
          field_check("near_z", want.near_z, out_result.near_z);
          field_check("distance", want.distance, out_result.distance);
          field_check("distance_squared", want.distance_squared,
                      out_result.distance_squared);
          field_check("lambda", want.lambda, out_result.lambda);
        end
      end
      if (start && !busy) begin
        if (search_predict(in_item, want)) awaited_hits.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == nve_pkg::CFG_VERTICES_IN_USE)
          vtx_count = (cfg_data[10:0] > NV) ? NV : cfg_data[10:0];
        else if (cfg_index == nve_pkg::CFG_EDGES_IN_USE)
          edge_count = (cfg_data > NE) ? NE : cfg_data;
      end
      // Watchdog on cycles in which no beat moves.
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("testbench NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Driver: present the next command beat, idling at random.
  always @(negedge clk) begin
    if (rst_n && (!start || took)) begin
      if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_item <= pending_cmds.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic nve_pkg::in_item_t cmd_beat(logic [1:0] op, int idx, int x, int y,
                                                 int z, bit en, int a, int b, int rad);
    nve_pkg::in_item_t c;
    c.command = op; c.entry_index = 11'(idx);
    c.coord_x = 24'(x); c.coord_y = 24'(y); c.coord_z = 24'(z);
    c.vertex_enabled = en; c.end_a = 10'(a); c.end_b = 10'(b); c.radius = 23'(rad);
    return c;
  endfunction

  function automatic int rand_coord(bit wide);
    if (wide) return $signed($urandom_range(24'hFFFFFF, 0) << 8) >>> 8;
    return int'($urandom_range(4096)) - 2048;
  endfunction

  // Random mix: loads and queries equally likely, mostly into a small table and queries near it.
  task automatic queue_random(int count, int span);
    nve_pkg::in_item_t c;
    bit wide;
    repeat (count) begin
      wide = $urandom_range(9) == 0;
      c = cmd_beat(nve_pkg::CMD_LOAD_VTX, 0, rand_coord(wide), rand_coord(wide),
                   rand_coord(wide), 0, 0, 0, 0);
      c.command = 2'($urandom_range(3));
      c.vertex_enabled = $urandom_range(4) != 0;
      c.entry_index = 11'(wide ? $urandom_range(2047) : $urandom_range(span - 1));
      c.end_a = 10'(wide ? $urandom_range(1023) : $urandom_range(span - 1));
      c.end_b = 10'(wide ? $urandom_range(1023) : $urandom_range(span - 1));
      c.radius = 23'(wide ? $urandom_range(23'h7FFFFF) : $urandom_range(3000));
      pending_cmds.push_back(c);
    end
  endtask

  // Wait until the block has drained every command and result.
  task automatic drain();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || start || busy || awaited_hits.size() != 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic cfg_write(logic [nve_pkg::CFG_IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= nve_pkg::CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_sizes(int nv, int ne);
    cfg_write(nve_pkg::CFG_VERTICES_IN_USE, nv);
    cfg_write(nve_pkg::CFG_EDGES_IN_USE, ne);
  endtask

  // Stimulus sequence.
  initial begin
    rst_n = 1'b0; start = 1'b0; in_item = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    errors = 0; queries_seen = 0; idle_pct = 0;
    vtx_count = 0; edge_count = 0;
    for (int i = 0; i < NV; i++) begin
      vtx_x[i] = '0; vtx_y[i] = '0; vtx_z[i] = '0; vtx_on[i] = 0;
    end
    for (int i = 0; i < NE; i++) begin
      edge_a[i] = '0; edge_b[i] = '0; edge_ok[i] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty tables: both searches find nothing.
    set_sizes(0, 0);
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_NEAR_VTX, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_NEAR_EDGE, 0, 0, 0, 0, 0, 0, 0,
                                    23'h7FFFFF));
    drain();

    // Directed loads and queries over the corner cases.
    set_sizes(16, 16);
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_LOAD_VTX, 0, 0, 0, 0, 1, 0, 0, 0));
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_LOAD_VTX, 1, 8388607, -8388608, 0,
                                    1, 0, 0, 0));
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_LOAD_VTX, 2, 256, 0, 0, 1, 0, 0, 0));
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_LOAD_VTX, 3, 256, 0, 0, 1, 0, 0, 0));
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_LOAD_VTX, 4, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_LOAD_VTX, 20, 10, 10, 10, 1, 0, 0, 0));
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_LOAD_VTX, 1024, 5, 5, 5, 1, 0, 0, 0));
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_LOAD_VTX, 2047, -1, -1, -1, 1, 0, 0, 0));
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_LOAD_EDGE, 0, 0, 0, 0, 0, 0, 2, 0));
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_LOAD_EDGE, 1, 0, 0, 0, 0, 5, 5, 0));
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_LOAD_EDGE, 2, 0, 0, 0, 0, 2, 3, 0));
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_LOAD_EDGE, 3, 0, 0, 0, 0, 0, 20, 0));
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_LOAD_EDGE, 4, 0, 0, 0, 0, 0, 4, 0));
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_LOAD_EDGE, 5, 0, 0, 0, 0, 0, 1, 0));
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_LOAD_EDGE, 2047, 0, 0, 0, 0, 1023,
                                    1022, 0));
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_NEAR_VTX, 0, -8388608, 8388607,
                                    -8388608, 0, 0, 0, 0));
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_NEAR_VTX, 0, 128, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_NEAR_EDGE, 0, 128, 256, 0, 0, 0, 0,
                                    23'h7FFFFF));
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_NEAR_EDGE, 0, 100, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_NEAR_EDGE, 0, -1000, 3, 0, 0, 0, 0,
                                    2000));
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_NEAR_EDGE, 0, 5000, -7, 9, 0, 0, 0,
                                    8000));
    pending_cmds.push_back(cmd_beat(nve_pkg::CMD_NEAR_EDGE, 0, 300, 0, 0, 0, 0, 0, 10));
    drain();

    // Random phases through several table sizes and idling patterns.
    idle_pct = 0;
    queue_random(35, 16);
    drain();
    set_sizes(12'hFFF, 12'hFFF);
    idle_pct = 81;
    queue_random(12, 16);
    drain();
    set_sizes(12, 24);
    queue_random(35, 24);
    drain();
    set_sizes(16, 16);
    idle_pct = 25;
    queue_random(35, 16);
    drain();
    set_sizes(1, 2048);
    idle_pct = 0;
    queue_random(10, 8);
    drain();

    $display("Ran directed and random loads and queries; %0d query results checked.",
             queries_seen);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

// File: nearest_vertex_and_edge_point_search.f
+incdir+hw/rtl
hw/rtl/nve_pkg.sv
hw/rtl/nve_datapath.sv
hw/rtl/nve_ctrl.sv
hw/rtl/nearest_vertex_and_edge_point_search.sv
dv/testbench.sv
